// ----- rtl/b64e_pkg.sv -----
// shared types, constants and alphabet lookup for the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

    // widths of one raw byte and of one sextet, which selects one output character
    localparam int ByteW   = 8;
    localparam int SextW   = 6;
    // most characters one byte can produce (final byte opening a group)
    localparam int GroupMax = 4;
    localparam int CntW     = $clog2(GroupMax + 1);

    // characters produced by one byte, handed from the split stage to the emitter
    typedef struct packed {
        logic [CntW-1:0]                 count;
        logic [GroupMax-1:0][SextW-1:0]  sext;   // sext[0] goes out first
        logic                            last;   // final character closes the message
    } t_group;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [ByteW-1:0] b64_char(input logic [SextW-1:0] sext);
        logic [ByteW-1:0] ch;
        begin
            case (sext) inside
                [6'd0  : 6'd25]: ch = 8'h41 + {2'b00, sext};
                [6'd26 : 6'd51]: ch = 8'h61 + {2'b00, sext} - 8'd26;
                [6'd52 : 6'd61]: ch = 8'h30 + {2'b00, sext} - 8'd52;
                6'd62:           ch = 8'h2b;
                default:         ch = 8'h2f;
            endcase
            return ch;
        end
    endfunction

endpackage

// ----- rtl/b64e_split.sv -----
// input register, group phase state and sextet split of one byte
`timescale 1ns / 1ps

module b64e_split (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_final,
    output logic               o_valid,
    input  logic               i_load,
    output b64e_pkg::t_group   o_group
);
    import b64e_pkg::*;

    // position of the byte within its three-byte group
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_final;
    logic [1:0]       r_phase;
    logic [1:0]       n_phase;
    logic [3:0]       r_left;
    logic [3:0]       n_left;
    logic             w_move;
    t_group           w_group;

    // transaction leaves for the emitter
    assign w_move  = r_valid && i_load;
    assign o_ready = !r_valid || i_load;
    assign o_valid = r_valid;
    assign o_group = w_group;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte  <= i_byte;
            r_final <= i_final;
        end
    end

    // split the byte into sextets by phase
    always_comb begin
        w_group       = '0;
        w_group.last  = r_final;
        n_phase       = PH_0;
        n_left        = 4'd0;
        case (r_phase)
            PH_1: begin
                w_group.sext[0] = {r_left[1:0], r_byte[7:4]};
                if (r_final) begin
                    w_group.sext[1] = {r_byte[3:0], 2'b00};
                    w_group.count   = CntW'(3);
                end else begin
                    w_group.count   = CntW'(1);
                    n_left          = r_byte[3:0];
                    n_phase         = PH_2;
                end
            end
            PH_2: begin
                w_group.sext[0] = {r_left, r_byte[7:6]};
                w_group.sext[1] = r_byte[5:0];
                w_group.count   = CntW'(2);
            end
            default: begin
                w_group.sext[0] = r_byte[7:2];
                if (r_final) begin
                    w_group.sext[1] = {r_byte[1:0], 4'b0000};
                    w_group.count   = CntW'(GroupMax);
                end else begin
                    w_group.count   = CntW'(1);
                    n_left          = {2'b00, r_byte[1:0]};
                    n_phase         = PH_1;
                end
            end
        endcase
    end

    // group state advances when the byte is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else if (w_move) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

// ----- rtl/b64e_emit.sv -----
// result buffer that sends the characters of one byte one at a time
`timescale 1ns / 1ps

module b64e_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_load,
    input  b64e_pkg::t_group   i_group,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_char,
    output logic               o_last
);
    import b64e_pkg::*;

    logic [CntW-1:0]                r_cnt;
    logic [GroupMax-1:0][SextW-1:0] r_sext;
    logic                           r_last;
    logic                           w_take;

    // buffer free once its last character is taken
    assign w_take  = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_load  = (r_cnt == '0) || ((r_cnt == CntW'(1)) && i_ready);
    assign o_char  = b64_char(r_sext[0]);
    assign o_last  = r_last && (r_cnt == CntW'(1));

    // count of characters still waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_load && i_valid) begin
            r_cnt <= i_group.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    // sextet queue, shifted down one slot per transaction
    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_sext <= i_group.sext;
            r_last <= i_group.last;
        end else if (w_take) begin
            r_sext <= r_sext >> SextW;
        end
    end

endmodule

// ----- rtl/base64_stream_encoder_top.sv -----
// top level of the base64 stream encoder
//
// channel  | direction | tdata                 | tlast
// s_axis   | in        | [7:0] data_byte       | final_byte
// m_axis   | out       | [7:0] code_char       | last_char
//
// a byte in the first or second place of a group yields one character, the third two;
// a final byte yields four in the first place, three in the second, two in the third
// a byte goes through the input register and the result buffer before its first character is offered
// reset clears the group phase, the pending bits and both valid flags
// a stalled output holds its character; input keeps flowing until the
// input register is full behind a busy buffer
`timescale 1ns / 1ps

module base64_stream_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] code_char
    output logic       o_m_axis_tlast
);
    import b64e_pkg::*;

    logic   w_valid;
    logic   w_load;
    t_group w_group;

    // byte capture and sextet split
    b64e_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_final (i_s_axis_tlast),
        .o_valid (w_valid),
        .i_load  (w_load),
        .o_group (w_group)
    );

    // character output
    b64e_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_load  (w_load),
        .i_group (w_group),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ----- rtl/b64e_check.sv -----
// port checker for the base64 stream encoder, bound to the top level
`timescale 1ns / 1ps

module b64e_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // nothing is offered on the output straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output transaction changed while stalled");

    // an empty output buffer never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // every character is from the alphabet
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata >= 8'h41 && o_m_axis_tdata <= 8'h5a) ||
            (o_m_axis_tdata >= 8'h61 && o_m_axis_tdata <= 8'h7a) ||
            (o_m_axis_tdata >= 8'h30 && o_m_axis_tdata <= 8'h39) ||
            o_m_axis_tdata == 8'h2b || o_m_axis_tdata == 8'h2f)
        else $error("character outside the alphabet");

endmodule

bind base64_stream_encoder_top b64e_check u_b64e_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
